// ----- design/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned SampleW      = 32;
  localparam int unsigned CfgW         = 11;
  localparam int unsigned WindowMaxDef = 1024;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input word
    logic pop_front;  // oldest candidate aged out
    logic pop_back;   // newest candidate dominated by the sample
    logic push;       // store the sample and load the result
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic front_old;
    logic back_dom;
    logic out_free;
  } swm_sts_t;

endpackage

// ----- design/swm_if.sv -----
`timescale 1ns / 1ps

interface swm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swm_pkg::SampleW-1:0] sample;
  logic                                first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

interface swm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swm_pkg::SampleW-1:0] window_min;

  modport source (output valid, output window_min, input ready);
  modport sink   (input valid, input window_min, output ready);
endinterface

// ----- design/swm_ram.sv -----
`timescale 1ns / 1ps

module swm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- design/swm_ctrl.sv -----
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t cmd_o
);

  import swm_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEval = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StEval;
        end
      end
      StEval: begin
        // aged-out front first, then dominated back, then insert
        if (sts_i.front_old) begin
          cmd_o.pop_front = 1'b1;
        end else if (sts_i.back_dom) begin
          cmd_o.pop_back = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/swm_dpath.sv -----
`timescale 1ns / 1ps

module swm_dpath #(
  parameter int unsigned WindowMax = swm_pkg::WindowMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swm_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic signed [swm_pkg::SampleW-1:0] sample_i,
  input  logic                                first_i,
  output logic                                out_valid_o,
  output logic signed [swm_pkg::SampleW-1:0] out_data_o,
  input  logic                                out_ready_i,
  input  swm_pkg::swm_cmd_t                   cmd_i,
  output swm_pkg::swm_sts_t                   sts_o
);

  import swm_pkg::*;

  localparam int unsigned AW = $clog2(WindowMax);
  localparam int unsigned CW = $clog2(WindowMax + 1);
  localparam int unsigned PW = AW + 1;   // ages stay at or below WindowMax
  localparam int unsigned SW = CW + 1;
  localparam int unsigned EW = PW + SampleW;

  logic [CfgW-1:0]          cfg_q;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;
  logic [PW-1:0]            pos_q;
  logic [PW-1:0]            cur_pos_q;
  logic [PW-1:0]            len_q;
  logic signed [SampleW-1:0] smp_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_data_q;

  logic [PW-1:0]            len_eff;
  logic [AW-1:0]            head_inc;
  logic [SW-1:0]            back_sum, ins_sum;
  logic [AW-1:0]            back_addr, ins_addr;
  logic [EW-1:0]            front_word, back_word;
  logic [PW-1:0]            front_pos, age;
  logic signed [SampleW-1:0] front_val, back_val;

  // clamp the window length to 1 .. WindowMax
  always_comb begin
    if (cfg_q == '0) begin
      len_eff = PW'(1);
    end else if (32'(cfg_q) > 32'(WindowMax)) begin
      len_eff = PW'(WindowMax);
    end else begin
      len_eff = PW'(cfg_q);
    end
  end

  assign head_inc = (head_q == AW'(WindowMax - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.accept && first_i) begin
      count_d = '0;
    end
    if (cmd_i.pop_front) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.pop_back) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end
  end

  // ring addresses, wrapped at WindowMax
  always_comb begin
    back_sum = SW'(head_d) + SW'(count_d) - SW'(1);
    if (back_sum >= SW'(WindowMax)) begin
      back_sum = back_sum - SW'(WindowMax);
    end
    ins_sum = SW'(head_q) + SW'(count_q);
    if (ins_sum >= SW'(WindowMax)) begin
      ins_sum = ins_sum - SW'(WindowMax);
    end
  end

  assign back_addr = back_sum[AW-1:0];
  assign ins_addr  = ins_sum[AW-1:0];

  swm_ram #(
    .Width (EW),
    .Depth (WindowMax)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.push),
    .waddr_i   (ins_addr),
    .wdata_i   ({cur_pos_q, smp_q}),
    .raddr_a_i (head_d),
    .rdata_a_o (front_word),
    .raddr_b_i (back_addr),
    .rdata_b_o (back_word)
  );

  assign front_pos = front_word[EW-1:SampleW];
  assign front_val = front_word[SampleW-1:0];
  assign back_val  = back_word[SampleW-1:0];
  assign age       = cur_pos_q - front_pos;

  assign sts_o.front_old = (count_q != '0) && (age >= len_q);
  assign sts_o.back_dom  = (count_q != '0) && (smp_q <= back_val);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgW'(1);
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        pos_q <= pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q     <= sample_i;
      cur_pos_q <= pos_q + PW'(1);
      len_q     <= len_eff;
    end
    if (cmd_i.push) begin
      out_data_q <= (count_q == '0) ? smp_q : front_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/sliding_window_minimum.sv -----
`timescale 1ns / 1ps

// sliding window minimum over a stream of signed 32-bit samples
// - in_i carries one word per sample: sample and first; first empties the
//   window before the sample goes in
// - out_o returns exactly one word per input word: window_min, the minimum
//   of the last window_length samples (or of all since the sequence began)
// - cfg_we_i / cfg_wdata_i write window_length; the user writes it only while
//   the block is idle, and the block itself does not enforce this; zero acts
//   as 1, values above WINDOW_MAX act as WINDOW_MAX
// - candidates live in a ring (dual read port RAM) with rising values from
//   front to back; each step pops aged-out fronts and dominated backs
// - after accept the controller pops aged-out fronts and dominated backs one
//   at a time, each pop a RAM read round trip through the controller, then
//   inserts the sample and loads the result register; the next word is taken
//   once the controller is idle again; every sample is popped at most once
// - result sits in an output register; a new word is accepted while it still
//   waits, and the block holds its insert step until the receiver drains it
// - reset empties the candidate store, clears the position counter and sets
//   window_length to 1; no RAM clearing pass is needed
module sliding_window_minimum #(
  parameter int unsigned WINDOW_MAX = swm_pkg::WindowMaxDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [swm_pkg::CfgW-1:0] cfg_wdata_i,
  swm_in_if.sink                   in_i,
  swm_out_if.source                out_o
);

  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;

  // sequencer: idle / evaluate
  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // candidate ring, counters and output register
  swm_dpath #(
    .WindowMax (WINDOW_MAX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (in_i.sample),
    .first_i     (in_i.first),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.window_min),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
